FILE: rtl/core/lus_pkg.sv
// ----------------------------------------------------------------------------
// LU solver package
// Shared constants, status codes and the divider status type.
// ----------------------------------------------------------------------------
package lus_pkg;

   localparam int LUS_MAX_ORDER  = 8;
   localparam int LUS_DATA_WIDTH = 32;
   localparam int LUS_FRAC_BITS  = 16;
   localparam int LUS_ORDER_RESET = 3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_PIVOT = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef struct packed {
      logic done;
      logic sat;
   } lus_div_status_type;

endpackage

FILE: rtl/core/lus_req_if.sv
// ----------------------------------------------------------------------------
// LU solver load channel
// Carries one element of the augmented matrix per transfer.
// ----------------------------------------------------------------------------
interface lus_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         row;
   logic [3:0]         col;
   logic signed [31:0] value;
   logic               last;

   modport source(output valid, output row, output col, output value, output last,
                  input ready);
   modport sink(input valid, input row, input col, input value, input last,
                output ready);
endinterface

FILE: rtl/core/lus_rsp_if.sv
// ----------------------------------------------------------------------------
// LU solver result channel
// Carries one solution element per transfer.
// ----------------------------------------------------------------------------
interface lus_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         index;
   logic signed [31:0] solution;
   logic [1:0]         status;
   logic               end_of_run;

   modport source(output valid, output index, output solution, output status,
                  output end_of_run, input ready);
   modport sink(input valid, input index, input solution, input status,
                input end_of_run, output ready);
endinterface

FILE: rtl/core/lus_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lus_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/lus_divider.sv
// ----------------------------------------------------------------------------
// LU solver divider
// Fixed-point quotient (a * 2^16) / b, rounded half away from zero and
// saturated, computed one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lus_divider import lus_pkg::*; #(
   parameter int WIDTH = LUS_DATA_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   a,
   input  logic [WIDTH-1:0]   b,
   output logic [WIDTH-1:0]   quotient,
   output lus_div_status_type status
);

   localparam int NW  = WIDTH + LUS_FRAC_BITS + 1;
   localparam int CNW = $clog2(NW + 1);
   localparam logic [NW-1:0] NEG_LIM = NW'(64'd1 << (WIDTH - 1));
   localparam logic [NW-1:0] POS_LIM = NW'((64'd1 << (WIDTH - 1)) - 64'd1);

   logic             busy_ff, busy_in;
   logic             fin_ff, fin_in;
   logic             done_ff, done_in;
   logic [CNW-1:0]   cnt_ff, cnt_in;
   logic [NW-1:0]    num_ff, num_in;
   logic [NW-1:0]    q_ff, q_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic             neg_ff, neg_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic             sat_ff, sat_in;

   logic [WIDTH-1:0] mag_a, mag_b;
   logic [WIDTH:0]   trial;
   logic             fits;

   assign mag_a = a[WIDTH-1] ? (~a + WIDTH'(1)) : a;
   assign mag_b = b[WIDTH-1] ? (~b + WIDTH'(1)) : b;
   assign trial = {rem_ff, num_ff[NW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = (NW'(mag_a) << LUS_FRAC_BITS) + NW'(mag_b >> 1);
         den_in  = mag_b;
         rem_in  = '0;
         neg_in  = a[WIDTH-1] ^ b[WIDTH-1];
      end else if (busy_ff) begin
         rem_in = fits ? WIDTH'(trial - {1'b0, den_ff}) : trial[WIDTH-1:0];
         q_in   = {q_ff[NW-2:0], fits};
         num_in = num_ff << 1;
         cnt_in = cnt_ff + CNW'(1);
         if (cnt_ff == CNW'(NW - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         // Clamp the magnitude to the signed range before applying the sign.
         if (neg_ff) begin
            sat_in = q_ff > NEG_LIM;
            quo_in = sat_in ? {1'b1, {(WIDTH-1){1'b0}}} : (~q_ff[WIDTH-1:0] + WIDTH'(1));
         end else begin
            sat_in = q_ff > POS_LIM;
            quo_in = sat_in ? {1'b0, {(WIDTH-1){1'b1}}} : q_ff[WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign quotient    = quo_ff;
   assign status.done = done_ff;
   assign status.sat  = sat_ff;

endmodule

FILE: rtl/core/lu_linear_solver_top.sv
// ----------------------------------------------------------------------------
// LU linear solver
// Loads [A|b] element by element, then factors A = LU in place (no pivoting)
// and solves by forward and back substitution in signed Q16.16.
// ----------------------------------------------------------------------------
// A load transfer with last set starts the solve: the matrix updates and
// the substitution products run through the shared multiply, round and
// subtract steps, and each divide is preceded by the read of its operand.
// Throughput: one load per cycle while idle, with loads stalled during a
// solve; one solve at a time, each result read from memory and then sent.
// Reset: order returns to 3 and the error flags clear; the matrix and vector
// memories hold undefined data until written.
// ----------------------------------------------------------------------------
module lu_linear_solver_top import lus_pkg::*; #(
   parameter int MAX_ORDER  = LUS_MAX_ORDER,
   parameter int DATA_WIDTH = LUS_DATA_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   lus_req_if.sink    req_chan,
   lus_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata
);

   // Values never exceed 32 bits of range, so the word size is capped there.
   localparam int SW  = DATA_WIDTH > 32 ? 32 : DATA_WIDTH;
   localparam int IW  = MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1;
   localparam int CW  = $clog2(MAX_ORDER + 1);
   localparam int MAW = 2 * IW;
   localparam int PW  = 2 * SW;
   localparam int RW  = PW + 1 - LUS_FRAC_BITS;

   localparam logic [RW-1:0] NEG_LIM = RW'(64'd1 << (SW - 1));
   localparam logic [RW-1:0] POS_LIM = RW'((64'd1 << (SW - 1)) - 64'd1);
   localparam logic [PW:0]   RND_HALF = (PW + 1)'(1) << (LUS_FRAC_BITS - 1);
   localparam logic signed [31:0] LD_MAX = 32'((64'd1 << (SW - 1)) - 64'd1);
   localparam logic signed [31:0] LD_MIN = ~LD_MAX;
   localparam logic [SW-1:0] VAL_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] VAL_MIN = {1'b1, {(SW-1){1'b0}}};

   // The sequencer walks the three loop nests of the solve, at most one memory
   // access per step. The multiply, round and subtract steps are shared by all three
   // phases; the phase register picks where they return to.
   typedef enum logic [25:0] {
      S_IDLE    = 26'd1 << 0,
      S_F_K     = 26'd1 << 1,
      S_F_PIV   = 26'd1 << 2,
      S_F_I     = 26'd1 << 3,
      S_F_LDIV  = 26'd1 << 4,
      S_F_LWAIT = 26'd1 << 5,
      S_F_J     = 26'd1 << 6,
      S_F_T     = 26'd1 << 7,
      S_F_A     = 26'd1 << 8,
      S_MUL     = 26'd1 << 9,
      S_RND     = 26'd1 << 10,
      S_SUB     = 26'd1 << 11,
      S_FW_I    = 26'd1 << 12,
      S_FW_ACC  = 26'd1 << 13,
      S_FW_J    = 26'd1 << 14,
      S_FW_M    = 26'd1 << 15,
      S_FW_V    = 26'd1 << 16,
      S_BK_I    = 26'd1 << 17,
      S_BK_ACC  = 26'd1 << 18,
      S_BK_J    = 26'd1 << 19,
      S_BK_M    = 26'd1 << 20,
      S_BK_V    = 26'd1 << 21,
      S_BK_D    = 26'd1 << 22,
      S_BK_DW   = 26'd1 << 23,
      S_EM_RD   = 26'd1 << 24,
      S_EM_WR   = 26'd1 << 25
   } state_type;

   typedef enum logic [1:0] {
      PH_FACTOR  = 2'd0,
      PH_FORWARD = 2'd1,
      PH_BACK    = 2'd2
   } phase_type;

   state_type      state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [3:0]     order_ff, order_in;
   logic [1:0]     err_ff, err_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [CW-1:0]  i_ff, i_in;
   logic [CW-1:0]  j_ff, j_in;
   logic [SW-1:0]  piv_ff, piv_in;
   logic [SW-1:0]  opa_ff, opa_in;
   logic [SW-1:0]  opb_ff, opb_in;
   logic [SW-1:0]  acc_ff, acc_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic           pneg_ff, pneg_in;
   logic [SW-1:0]  p_ff, p_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_index_ff, rsp_index_in;
   logic signed [31:0] rsp_sol_ff, rsp_sol_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_end_ff, rsp_end_in;

   // Memory ports.
   logic           m_we, m_re;
   logic [MAW-1:0] m_waddr, m_raddr;
   logic [SW-1:0]  m_wdata, m_rdata;
   logic           v_we, v_re;
   logic [IW-1:0]  v_waddr, v_raddr;
   logic [SW-1:0]  v_wdata, v_rdata;

   // Divider.
   logic               div_start;
   logic [SW-1:0]      div_a, div_b, div_q;
   lus_div_status_type div_status;

   logic               accept;
   logic [4:0]         order_w;
   logic [CW-1:0]      n_cur;
   logic               in_range;
   logic signed [31:0] ld_clip;
   logic [SW-1:0]      ld_val;
   logic [SW-1:0]      mag_a, mag_b;
   logic [PW:0]        rsum;
   logic [RW-1:0]      rmag;
   logic               rnd_sat;
   logic [SW-1:0]      rnd_val;
   logic signed [SW:0] diff_w;
   logic               sub_sat;
   logic [SW-1:0]      sub_val;
   logic               rsp_free;

   function automatic logic [MAW-1:0] maddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return {r[IW-1:0], c[IW-1:0]};
   endfunction

   lus_ram #(
      .WIDTH (SW),
      .DEPTH (1 << MAW)
   ) u_matrix_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .re    (m_re),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   lus_ram #(
      .WIDTH (SW),
      .DEPTH (1 << IW)
   ) u_vector_ram (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (v_wdata),
      .re    (v_re),
      .raddr (v_raddr),
      .rdata (v_rdata)
   );

   lus_divider #(
      .WIDTH (SW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .a        (div_a),
      .b        (div_b),
      .quotient (div_q),
      .status   (div_status)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // An order of zero acts as one, and anything above the maximum is clipped.
   assign order_w = {1'b0, order_ff};
   assign n_cur   = (order_w == 5'd0) ? CW'(1) :
                    (order_w > 5'(MAX_ORDER)) ? CW'(MAX_ORDER) : CW'(order_w);
   assign in_range = (5'(req_chan.row) < 5'(n_cur)) && (5'(req_chan.col) <= 5'(n_cur));

   // Loaded values are clipped to the word range without raising a flag.
   assign ld_clip = (req_chan.value > LD_MAX) ? LD_MAX :
                    (req_chan.value < LD_MIN) ? LD_MIN : req_chan.value;
   assign ld_val  = ld_clip[SW-1:0];

   // Sign-magnitude multiply; the product is registered before rounding.
   assign mag_a = opa_ff[SW-1] ? (~opa_ff + SW'(1)) : opa_ff;
   assign mag_b = opb_ff[SW-1] ? (~opb_ff + SW'(1)) : opb_ff;

   // Round half away from zero on the magnitude, then saturate.
   assign rsum = {1'b0, prod_ff} + RND_HALF;
   assign rmag = rsum[PW:LUS_FRAC_BITS];
   always_comb begin
      if (pneg_ff) begin
         rnd_sat = rmag > NEG_LIM;
         rnd_val = rnd_sat ? VAL_MIN : (~rmag[SW-1:0] + SW'(1));
      end else begin
         rnd_sat = rmag > POS_LIM;
         rnd_val = rnd_sat ? VAL_MAX : rmag[SW-1:0];
      end
   end

   assign diff_w  = $signed({acc_ff[SW-1], acc_ff}) - $signed({p_ff[SW-1], p_ff});
   assign sub_sat = diff_w[SW] ^ diff_w[SW-1];
   assign sub_val = sub_sat ? (diff_w[SW] ? VAL_MIN : VAL_MAX) : diff_w[SW-1:0];

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      order_in      = csr_we ? csr_wdata : order_ff;
      err_in        = err_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      piv_in        = piv_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      pneg_in       = pneg_ff;
      p_in          = p_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_sol_in    = rsp_sol_ff;
      rsp_status_in = rsp_status_ff;
      rsp_end_in    = rsp_end_ff;

      m_we      = 1'b0;
      m_waddr   = '0;
      m_wdata   = '0;
      m_re      = 1'b0;
      m_raddr   = '0;
      v_we      = 1'b0;
      v_waddr   = '0;
      v_wdata   = '0;
      v_re      = 1'b0;
      v_raddr   = '0;
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (in_range) begin
                  if (5'(req_chan.col) == 5'(n_cur)) begin
                     v_we    = 1'b1;
                     v_waddr = IW'(req_chan.row);
                     v_wdata = ld_val;
                  end else begin
                     m_we    = 1'b1;
                     m_waddr = {IW'(req_chan.row), IW'(req_chan.col)};
                     m_wdata = ld_val;
                  end
               end
               if (req_chan.last) begin
                  n_in     = n_cur;
                  k_in     = '0;
                  err_in   = 2'b00;
                  phase_in = PH_FACTOR;
                  state_in = S_F_K;
               end
            end
         end

         // Factorization: outer loop over the pivot column k.
         S_F_K: begin
            if (k_ff < n_ff) begin
               m_re     = 1'b1;
               m_raddr  = maddr(k_ff, k_ff);
               state_in = S_F_PIV;
            end else begin
               i_in     = '0;
               phase_in = PH_FORWARD;
               state_in = S_FW_I;
            end
         end
         S_F_PIV: begin
            if (m_rdata == '0) begin
               // Zero pivot: stop and report a zero solution.
               err_in[0] = 1'b1;
               i_in      = '0;
               state_in  = S_EM_RD;
            end else begin
               piv_in   = m_rdata;
               i_in     = k_ff + CW'(1);
               state_in = S_F_I;
            end
         end
         S_F_I: begin
            if (i_ff < n_ff) begin
               m_re     = 1'b1;
               m_raddr  = maddr(i_ff, k_ff);
               state_in = S_F_LDIV;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_F_K;
            end
         end
         S_F_LDIV: begin
            div_start = 1'b1;
            div_a     = m_rdata;
            div_b     = piv_ff;
            state_in  = S_F_LWAIT;
         end
         S_F_LWAIT: begin
            if (div_status.done) begin
               m_we    = 1'b1;
               m_waddr = maddr(i_ff, k_ff);
               m_wdata = div_q;
               if (div_status.sat) begin
                  err_in[1] = 1'b1;
               end
               opa_in   = div_q;
               j_in     = k_ff + CW'(1);
               state_in = S_F_J;
            end
         end
         S_F_J: begin
            if (j_ff < n_ff) begin
               m_re     = 1'b1;
               m_raddr  = maddr(k_ff, j_ff);
               state_in = S_F_T;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_F_I;
            end
         end
         S_F_T: begin
            opb_in   = m_rdata;
            m_re     = 1'b1;
            m_raddr  = maddr(i_ff, j_ff);
            state_in = S_F_A;
         end
         S_F_A: begin
            acc_in   = m_rdata;
            state_in = S_MUL;
         end

         // Shared multiply, round and subtract.
         S_MUL: begin
            prod_in  = PW'(mag_a) * PW'(mag_b);
            pneg_in  = opa_ff[SW-1] ^ opb_ff[SW-1];
            state_in = S_RND;
         end
         S_RND: begin
            p_in = rnd_val;
            if (rnd_sat) begin
               err_in[1] = 1'b1;
            end
            state_in = S_SUB;
         end
         S_SUB: begin
            acc_in = sub_val;
            if (sub_sat) begin
               err_in[1] = 1'b1;
            end
            j_in = j_ff + CW'(1);
            case (phase_ff)
               PH_FACTOR: begin
                  m_we     = 1'b1;
                  m_waddr  = maddr(i_ff, j_ff);
                  m_wdata  = sub_val;
                  state_in = S_F_J;
               end
               PH_FORWARD: begin
                  state_in = S_FW_J;
               end
               PH_BACK: begin
                  state_in = S_BK_J;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // Forward substitution with the unit lower triangle.
         S_FW_I: begin
            if (i_ff < n_ff) begin
               v_re     = 1'b1;
               v_raddr  = i_ff[IW-1:0];
               state_in = S_FW_ACC;
            end else begin
               i_in     = n_ff - CW'(1);
               phase_in = PH_BACK;
               state_in = S_BK_I;
            end
         end
         S_FW_ACC: begin
            acc_in   = v_rdata;
            j_in     = '0;
            state_in = S_FW_J;
         end
         S_FW_J: begin
            if (j_ff < i_ff) begin
               m_re     = 1'b1;
               m_raddr  = maddr(i_ff, j_ff);
               state_in = S_FW_M;
            end else begin
               v_we     = 1'b1;
               v_waddr  = i_ff[IW-1:0];
               v_wdata  = acc_ff;
               i_in     = i_ff + CW'(1);
               state_in = S_FW_I;
            end
         end
         S_FW_M: begin
            opa_in   = m_rdata;
            v_re     = 1'b1;
            v_raddr  = j_ff[IW-1:0];
            state_in = S_FW_V;
         end
         S_FW_V: begin
            opb_in   = v_rdata;
            state_in = S_MUL;
         end

         // Back substitution with the upper triangle, last row first.
         S_BK_I: begin
            v_re     = 1'b1;
            v_raddr  = i_ff[IW-1:0];
            state_in = S_BK_ACC;
         end
         S_BK_ACC: begin
            acc_in   = v_rdata;
            j_in     = i_ff + CW'(1);
            state_in = S_BK_J;
         end
         S_BK_J: begin
            m_re = 1'b1;
            if (j_ff < n_ff) begin
               m_raddr  = maddr(i_ff, j_ff);
               state_in = S_BK_M;
            end else begin
               m_raddr  = maddr(i_ff, i_ff);
               state_in = S_BK_D;
            end
         end
         S_BK_M: begin
            opa_in   = m_rdata;
            v_re     = 1'b1;
            v_raddr  = j_ff[IW-1:0];
            state_in = S_BK_V;
         end
         S_BK_V: begin
            opb_in   = v_rdata;
            state_in = S_MUL;
         end
         S_BK_D: begin
            div_start = 1'b1;
            div_a     = acc_ff;
            div_b     = m_rdata;
            state_in  = S_BK_DW;
         end
         S_BK_DW: begin
            if (div_status.done) begin
               v_we    = 1'b1;
               v_waddr = i_ff[IW-1:0];
               v_wdata = div_q;
               if (div_status.sat) begin
                  err_in[1] = 1'b1;
               end
               if (i_ff == '0) begin
                  state_in = S_EM_RD;
               end else begin
                  i_in     = i_ff - CW'(1);
                  state_in = S_BK_I;
               end
            end
         end

         // Result emission in index order.
         S_EM_RD: begin
            v_re     = 1'b1;
            v_raddr  = i_ff[IW-1:0];
            state_in = S_EM_WR;
         end
         S_EM_WR: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = 3'(i_ff);
               rsp_sol_in    = err_ff[0] ? 32'sd0 : 32'($signed(v_rdata));
               rsp_status_in = err_ff[0] ? STATUS_PIVOT :
                               (err_ff[1] ? STATUS_SAT : STATUS_OK);
               rsp_end_in    = (i_ff + CW'(1) == n_ff);
               if (i_ff + CW'(1) == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = S_EM_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FACTOR;
         order_ff     <= 4'(LUS_ORDER_RESET);
         err_ff       <= 2'b00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         order_ff     <= order_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      piv_ff        <= piv_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      pneg_ff       <= pneg_in;
      p_ff          <= p_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_sol_ff    <= rsp_sol_in;
      rsp_status_ff <= rsp_status_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.index      = rsp_index_ff;
   assign rsp_chan.solution   = rsp_sol_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.end_of_run = rsp_end_ff;

endmodule

FILE: verif/lu_linear_solver_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LU linear solver testbench
// Loads augmented systems of many orders through the load channel, starts
// each solve with the last flag, and compares every solution transfer with
// the results of a bit-exact Q16.16 LU solver kept inside the testbench.
// ----------------------------------------------------------------------------
module lu_linear_solver_top_test;
   import lus_pkg::*;

   localparam int NMAX = LUS_MAX_ORDER;
   localparam longint FX_MAX = 64'sd2147483647;
   localparam longint FX_MIN = -64'sd2147483648;
   // The idle limit covers a solve at the largest order together with the
   // long receiver hold-off.
   localparam int IDLE_LIMIT = 20000;
   localparam int ITEM_GOAL  = 320;

   typedef enum logic [0:0] {OP_LOAD, OP_ORDER} step_op_type;

   typedef struct {
      step_op_type op;
      logic [2:0]  row;
      logic [3:0]  col;
      logic [31:0] value;
      logic        last;
      bit          typed;
      logic [31:0] x;
      logic [1:0]  st;
   } step_type;

   typedef struct {
      logic [2:0]  index;
      logic [31:0] solution;
      logic [1:0]  status;
      logic        end_of_run;
   } soln_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [3:0] csr_wdata;

   lus_req_if req ();
   lus_rsp_if rsp ();

   lu_linear_solver_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the solver state: the factored matrix, the vector that
   // goes from b to y to x, the order register and the saturation flag.
   longint     lu_mat [NMAX*NMAX];
   longint     xb_vec [NMAX];
   bit         mat_written [NMAX*NMAX];
   bit         vec_written [NMAX];
   logic [3:0] order_reg;
   bit         flag_sat;

   soln_type solutions_due [$];
   int       fail_count;
   int       loads_stored;
   int       idle_cycles;
   bit       stim_done;

   // The directed part. Order 0 acts as order 1, so the single-element
   // solves below can be read off by hand: x = b / a.
   step_type directed [15] = '{
      '{OP_ORDER, 3'd0, 4'd0, 32'd0, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd0, 4'd0, 32'h0001_0000, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd0, 4'd1, 32'h0003_0000, 1'b1, 1'b1, 32'h0003_0000, STATUS_OK},
      // A zero pivot zeroes the solution.
      '{OP_LOAD, 3'd0, 4'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, STATUS_PIVOT},
      // The smallest pivot blows the quotient past the top of the range.
      '{OP_LOAD, 3'd0, 4'd0, 32'h0000_0001, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd0, 4'd1, 32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, STATUS_SAT},
      // The most negative value divided by one lands exactly on the bottom.
      '{OP_LOAD, 3'd0, 4'd0, 32'h0001_0000, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd0, 4'd1, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, STATUS_OK},
      // Out-of-range loads are dropped; a dropped load with last set still
      // solves again on what the stores hold.
      '{OP_LOAD, 3'd5, 4'd0, 32'h0000_1234, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd0, 4'd3, 32'hffff_ffff, 1'b1, 1'b0, 32'd0, STATUS_OK},
      '{OP_ORDER, 3'd0, 4'd2, 32'd0, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd0, 4'd1, 32'h0002_0000, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd1, 4'd0, 32'h0001_0000, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd1, 4'd1, 32'h0003_0000, 1'b0, 1'b0, 32'd0, STATUS_OK},
      '{OP_LOAD, 3'd1, 4'd2, 32'hfffc_0000, 1'b0, 1'b0, 32'd0, STATUS_OK}
   };

   // ------------------------------------------------------------------
   // Clock and reset. Reset is applied once, at the start of the run.
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Q16.16 arithmetic, saturating to 32 bits and noting the saturation.
   // ------------------------------------------------------------------
   function automatic longint clip(longint v);
      if (v > FX_MAX) begin
         flag_sat = 1'b1;
         return FX_MAX;
      end
      if (v < FX_MIN) begin
         flag_sat = 1'b1;
         return FX_MIN;
      end
      return v;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint q_mul(longint a, longint b);
      longint unsigned m;
      m = (magnitude(a) * magnitude(b) + 64'd32768) >> 16;
      return clip(((a < 0) != (b < 0)) ? -longint'(m) : longint'(m));
   endfunction

   function automatic longint q_div(longint a, longint b);
      longint unsigned num, den, q;
      num = magnitude(a) << 16;
      den = magnitude(b);
      q   = (num + den / 2) / den;
      return clip(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
   endfunction

   function automatic int active_order();
      if (order_reg == 4'd0) return 1;
      if (order_reg > NMAX) return NMAX;
      return int'(order_reg);
   endfunction

   // Doolittle factorization in place, then forward and back substitution.
   // Queues one expected solution element per index.
   function automatic void solve_system();
      int n;
      bit ok;
      longint piv, l, acc;
      logic [1:0] st;
      soln_type s;
      n = active_order();
      ok = 1'b1;
      flag_sat = 1'b0;
      for (int k = 0; k < n && ok; k++) begin
         piv = lu_mat[k*NMAX+k];
         if (piv == 0) begin
            ok = 1'b0;
         end else begin
            for (int i = k + 1; i < n; i++) begin
               l = q_div(lu_mat[i*NMAX+k], piv);
               lu_mat[i*NMAX+k] = l;
               for (int j = k + 1; j < n; j++)
                  lu_mat[i*NMAX+j] = clip(lu_mat[i*NMAX+j] - q_mul(l, lu_mat[k*NMAX+j]));
            end
         end
      end
      if (ok) begin
         for (int i = 0; i < n; i++)
            for (int j = 0; j < i; j++)
               xb_vec[i] = clip(xb_vec[i] - q_mul(lu_mat[i*NMAX+j], xb_vec[j]));
         for (int i = n - 1; i >= 0; i--) begin
            acc = xb_vec[i];
            for (int j = i + 1; j < n; j++)
               acc = clip(acc - q_mul(lu_mat[i*NMAX+j], xb_vec[j]));
            xb_vec[i] = q_div(acc, lu_mat[i*NMAX+i]);
         end
      end
      st = !ok ? STATUS_PIVOT : (flag_sat ? STATUS_SAT : STATUS_OK);
      for (int i = 0; i < n; i++) begin
         s.index      = 3'(i);
         s.solution   = ok ? xb_vec[i][31:0] : 32'd0;
         s.status     = st;
         s.end_of_run = (i == n - 1);
         solutions_due.push_back(s);
      end
   endfunction

   // Stores one accepted element that lies within the order and, with last set, solves.
   function automatic void absorb_load(logic [2:0] row, logic [3:0] col,
                                       logic [31:0] value, logic last);
      int n;
      n = active_order();
      if (row < n && col <= n) begin
         loads_stored++;
         if (col == n) begin
            xb_vec[row] = longint'($signed(value));
            vec_written[row] = 1'b1;
         end else begin
            lu_mat[row*NMAX+col] = longint'($signed(value));
            mat_written[row*NMAX+col] = 1'b1;
         end
      end
      if (last) solve_system();
   endfunction

   function automatic bit stores_ready(int n);
      for (int r = 0; r < n; r++) begin
         if (!vec_written[r]) return 1'b0;
         for (int c = 0; c < n; c++)
            if (!mat_written[r*NMAX+c]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Mostly back-to-back, sometimes a short gap, rarely a long gap.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // Load channel driver. The valid stays high after a transfer so that a
   // following item can go out back to back; callers lower it in the same
   // time step when nothing follows at once.
   // ------------------------------------------------------------------
   task automatic send_load(logic [2:0] row, logic [3:0] col, logic [31:0] value,
                            logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.row   <= row;
      req.col   <= col;
      req.value <= value;
      req.last  <= last;
      do @(posedge clock); while (!req.ready);
      absorb_load(row, col, value, last);
   endtask

   // Writes the order register once the block has gone quiet. Loads are taken
   // at once while idle, so a short settle covers any trailing dropped element.
   task automatic write_order(logic [3:0] val);
      req.valid <= 1'b0;
      while (solutions_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      order_reg = val;
   endtask

   function automatic logic [31:0] pick_value(bit diag);
      int r;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 3) return 32'd0;
      if (r < 8) return $urandom;
      if (diag) begin
         v = {16'($urandom_range(1, 8)), 16'($urandom)};
      end else begin
         v = {16'($urandom_range(0, 1)), 16'($urandom)};
      end
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // An element that the block drops: row or column beyond the order.
   task automatic send_noise(int n, logic last);
      logic [2:0] row;
      logic [3:0] col;
      if (n < NMAX && $urandom_range(0, 1)) begin
         row = 3'($urandom_range(n, NMAX - 1));
         col = 4'($urandom);
      end else begin
         row = 3'($urandom);
         col = 4'($urandom_range(n + 1, 15));
      end
      send_load(row, col, $urandom, last);
   endtask

   // One solve: either a full load in shuffled order, or a partial reload
   // of a system that is already complete, ending in the last flag.
   task automatic run_solve();
      int n, k, t;
      int cells [$];
      n = active_order();
      if (stores_ready(n) && $urandom_range(0, 9) < 2) begin
         k = $urandom_range(0, 3);
         repeat (k) begin
            t = $urandom_range(0, n * (n + 1) - 1);
            send_load(3'(t / (n + 1)), 4'(t % (n + 1)),
                      pick_value((t / (n + 1)) == (t % (n + 1))), 1'b0);
         end
         if ($urandom_range(0, 1)) begin
            send_noise(n, 1'b1);
         end else begin
            t = $urandom_range(0, n * (n + 1) - 1);
            send_load(3'(t / (n + 1)), 4'(t % (n + 1)),
                      pick_value((t / (n + 1)) == (t % (n + 1))), 1'b1);
         end
      end else begin
         for (int i = 0; i < n * (n + 1); i++) cells.push_back(i);
         cells.shuffle();
         foreach (cells[i]) begin
            if ($urandom_range(0, 9) == 0) send_noise(n, 1'b0);
            t = cells[i];
            send_load(3'(t / (n + 1)), 4'(t % (n + 1)),
                      pick_value((t / (n + 1)) == (t % (n + 1))),
                      i == cells.size() - 1);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus: directed table, then random solves over a spread of orders.
   // ------------------------------------------------------------------
   initial begin
      int big_sets, r;
      soln_type s;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_wdata = 4'd0;
      req.valid = 1'b0;
      req.row   = 3'd0;
      req.col   = 4'd0;
      req.value = 32'd0;
      req.last  = 1'b0;
      order_reg = 4'(LUS_ORDER_RESET);
      big_sets  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].op == OP_ORDER) begin
            write_order(directed[i].col);
         end else begin
            send_load(directed[i].row, directed[i].col, directed[i].value,
                      directed[i].last);
            // Hand-worked rows replace what the solver model queued.
            if (directed[i].typed) begin
               void'(solutions_due.pop_back());
               s.index      = 3'd0;
               s.solution   = directed[i].x;
               s.status     = directed[i].st;
               s.end_of_run = 1'b1;
               solutions_due.push_back(s);
            end
         end
      end
      // Close the order-2 system started at the end of the table.
      send_load(3'd0, 4'd2, 32'h0005_0000, 1'b1);

      loads_stored = 0;
      while (loads_stored < ITEM_GOAL) begin
         r = $urandom_range(0, 19);
         if (r == 0) write_order(4'd0);
         else if (r == 1 && big_sets < 2) begin
            write_order(4'd8);
            big_sets++;
         end else if (r == 2 && big_sets < 2) begin
            write_order(4'($urandom_range(9, 15)));
            big_sets++;
         end else write_order(4'($urandom_range(1, 4)));
         repeat ((active_order() == NMAX) ? 1 : $urandom_range(1, 3)) run_solve();
      end
      req.valid <= 1'b0;

      while (solutions_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      stim_done = 1'b1;
      if (fail_count == 0) begin
         $display("lu_linear_solver_top_test: PASS");
      end else begin
         $display("lu_linear_solver_top_test: FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Result receiver. Random stalls, some stall-free stretches, and one
   // long hold-off in the second half, started while a result waits and
   // the driver is offering a load, so the block backs up and the load
   // channel stays stalled.
   // ------------------------------------------------------------------
   initial begin
      int stall, free_run;
      bit held;
      rsp.ready = 1'b0;
      stall     = 0;
      free_run  = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && loads_stored > ITEM_GOAL / 2 && rsp.valid &&
             req.valid && !req.ready) begin
            held     = 1'b1;
            stall    = 600;
            free_run = 0;
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            stall--;
         end else if (free_run > 0) begin
            rsp.ready <= 1'b1;
            free_run--;
         end else begin
            r_pick: begin
               int r;
               r = $urandom_range(0, 99);
               if (r < 5) free_run = $urandom_range(50, 200);
               else if (r < 30) stall = pick_gap();
               rsp.ready <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker: every solution transfer against the oldest due one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      soln_type s;
      if (!reset && rsp.valid && rsp.ready) begin
         if (solutions_due.size() == 0) begin
            $error("unexpected solution transfer: index %0d value %h",
                   rsp.index, rsp.solution);
            fail_count++;
         end else begin
            s = solutions_due.pop_front();
            if (rsp.index !== s.index) begin
               $error("index: expected %0d, got %0d", s.index, rsp.index);
               fail_count++;
            end
            if (rsp.solution !== s.solution) begin
               $error("solution: expected %h, got %h", s.solution, rsp.solution);
               fail_count++;
            end
            if (rsp.status !== s.status) begin
               $error("status: expected %0d, got %0d", s.status, rsp.status);
               fail_count++;
            end
            if (rsp.end_of_run !== s.end_of_run) begin
               $error("end_of_run: expected %b, got %b", s.end_of_run, rsp.end_of_run);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (!stim_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("lu_linear_solver_top_test: FAIL");
            $finish;
         end
      end
   end

   initial begin
      fail_count   = 0;
      loads_stored = 0;
      idle_cycles  = 0;
      stim_done    = 1'b0;
      foreach (mat_written[i]) mat_written[i] = 1'b0;
      foreach (vec_written[i]) vec_written[i] = 1'b0;
   end

endmodule

FILE: filelist.f
rtl/core/lus_pkg.sv
rtl/core/lus_req_if.sv
rtl/core/lus_rsp_if.sv
rtl/core/lus_ram.sv
rtl/core/lus_divider.sv
rtl/core/lu_linear_solver_top.sv
verif/lu_linear_solver_top_test.sv
